// File: hw/rtl/ilha_pkg.sv
// Shared types and constants for the implicit list heap allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none

package ilha_pkg;

  localparam int unsigned HEAP_BYTES = 64;
  localparam int unsigned AW         = $clog2(HEAP_BYTES);
  localparam logic [5:0]  MaxBlocks  = 6'd63;
  localparam logic [7:0]  TooBig     = 8'd127;
  localparam logic [7:0]  MaxOut     = 8'd62;

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_HEADER = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_TOO_BIG   = 3'd1,
    STS_NO_SPACE  = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_NOT_ALLOC = 3'd4,
    STS_BEYOND    = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] target_id;
    logic [7:0] request_amount;
    logic [7:0] fill_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] result_id;
    logic [7:0] result_size;
    logic       result_allocated;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_WALK, S_ID, S_HDR, S_EVAL, S_SPLIT_ID, S_SPLIT_HDR,
    S_SET_ID, S_SET_HDR, S_TAIL, S_FILL, S_RD_ADDR, S_RD_DATA
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WALK_INIT, OP_RD_ID, OP_RD_HDR, OP_CAP_HDR, OP_STEP,
    OP_FIT, OP_WR_SPLIT_ID, OP_WR_SPLIT_HDR, OP_WR_ID, OP_WR_HDR, OP_TAIL,
    OP_WR_FREE, OP_WR_FILL, OP_RD_BYTE
  } dp_op_e;

  typedef enum logic [2:0] {
    RSP_PLAIN, RSP_ALLOC, RSP_FREE, RSP_HEADER, RSP_DATA
  } rsp_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     next_byte;
    logic     emit;
    status_e  status;
    rsp_sel_e sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       walk_end;
    logic       id_match;
    logic       fits;
    logic       split;
    logic       blk_alloc;
    logic       too_big;
    logic       table_full;
    logic       rd_bound;
    logic       tail_short;
    logic       amt_over;
    logic       amt_zero;
    logic       fill_done;
    logic       read_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/ilha_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module ilha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ilha_ctrl.sv
// Sequencing state machine of the heap allocator.
// Depends on ilha_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module ilha_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire ilha_pkg::dp_sts_t  sts_i,
  output ilha_pkg::ctl_cmd_t      cmd_o,
  output logic                    busy_o
);
  import ilha_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, next_byte: 1'b0, emit: 1'b0, status: STS_OK, sel: RSP_PLAIN};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_WALK;
        if (sts_i.action == ACT_ALLOC) begin
          if (sts_i.too_big) begin
            cmd_o.emit = 1'b1; cmd_o.status = STS_TOO_BIG; state_d = S_IDLE;
          end else if (sts_i.table_full) begin
            cmd_o.emit = 1'b1; cmd_o.status = STS_NO_SPACE; state_d = S_IDLE;
          end
        end else if (sts_i.action == ACT_READ) begin
          if (sts_i.rd_bound) begin
            cmd_o.emit = 1'b1; cmd_o.status = STS_BEYOND; state_d = S_IDLE;
          end
        end else if (sts_i.action != ACT_FREE && sts_i.action != ACT_WRITE &&
                     sts_i.action != ACT_HEADER) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          if (sts_i.action == ACT_ALLOC) begin
            state_d = S_TAIL;
          end else begin
            cmd_o.emit = 1'b1; cmd_o.status = STS_NOT_FOUND; state_d = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_RD_ID;
          state_d  = S_ID;
        end
      end
      S_ID: begin
        cmd_o.op = OP_RD_HDR;
        state_d  = S_HDR;
      end
      S_HDR: begin
        cmd_o.op = OP_CAP_HDR;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.action == ACT_ALLOC) begin
          if (sts_i.fits) begin
            cmd_o.op = OP_FIT;
            state_d  = sts_i.split ? S_SPLIT_ID : S_SET_ID;
          end else begin
            cmd_o.op = OP_STEP;
            state_d  = S_WALK;
          end
        end else if (!sts_i.id_match) begin
          cmd_o.op = OP_STEP;
          state_d  = S_WALK;
        end else begin
          state_d    = S_IDLE;
          cmd_o.emit = 1'b1;
          if (sts_i.action == ACT_HEADER) begin
            cmd_o.sel = RSP_HEADER;
          end else if (!sts_i.blk_alloc) begin
            cmd_o.status = STS_NOT_ALLOC;
          end else if (sts_i.action == ACT_FREE) begin
            cmd_o.op  = OP_WR_FREE;
            cmd_o.sel = RSP_FREE;
          end else if (sts_i.amt_over) begin
            cmd_o.status = STS_BEYOND;
          end else if (sts_i.action == ACT_WRITE) begin
            cmd_o.emit = 1'b0;
            state_d    = S_FILL;
          end else if (!sts_i.amt_zero) begin
            cmd_o.emit = 1'b0;
            state_d    = S_RD_ADDR;
          end
        end
      end
      S_SPLIT_ID: begin
        cmd_o.op = OP_WR_SPLIT_ID;
        state_d  = S_SPLIT_HDR;
      end
      S_SPLIT_HDR: begin
        cmd_o.op = OP_WR_SPLIT_HDR;
        state_d  = S_SET_ID;
      end
      S_SET_ID: begin
        cmd_o.op = OP_WR_ID;
        state_d  = S_SET_HDR;
      end
      S_SET_HDR: begin
        cmd_o.op   = OP_WR_HDR;
        cmd_o.emit = 1'b1;
        cmd_o.sel  = RSP_ALLOC;
        state_d    = S_IDLE;
      end
      S_TAIL: begin
        if (sts_i.tail_short) begin
          cmd_o.emit = 1'b1; cmd_o.status = STS_NO_SPACE; state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_TAIL;
          state_d  = S_SET_ID;
        end
      end
      S_FILL: begin
        if (sts_i.fill_done) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.op = OP_WR_FILL;
        end
      end
      S_RD_ADDR: begin
        cmd_o.op = OP_RD_BYTE;
        state_d  = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.next_byte = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.sel       = RSP_DATA;
        state_d         = sts_i.read_last ? S_IDLE : S_RD_ADDR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/ilha_dp.sv
// Datapath of the heap allocator: heap RAM, walk pointers, counters and result register.
// Depends on ilha_pkg and ilha_ram.
`default_nettype none

module ilha_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ilha_pkg::req_t     req_i,
  input  wire ilha_pkg::ctl_cmd_t cmd_i,
  output ilha_pkg::dp_sts_t       sts_o,
  output logic                    valid_o,
  output ilha_pkg::rsp_t          rsp_o
);
  import ilha_pkg::*;

  req_t        req_q;
  logic [7:0]  pos_q, j_q, ts_q, id_q, hdr_q, idc_q, tail_q;
  logic [5:0]  i_q, cnt_q;
  logic [HEAP_BYTES-1:0] vld_q;
  logic        rzero_q;
  logic        valid_q;
  rsp_t        rsp_q, rsp_d;

  logic [7:0]  ram_rdata, rdata, sz, diff, tdiff, ts_eff;
  logic [8:0]  waddr, raddr;
  logic [7:0]  wdata;
  logic        we, re, wr_ok;

  assign rdata = rzero_q ? 8'd0 : ram_rdata;
  // A size field of zero stands for 128 bytes.
  assign sz    = (hdr_q[7:1] == 7'd0) ? 8'd128 : {1'b0, hdr_q[7:1]};
  assign diff  = sz - ts_q;
  assign tdiff = tail_q - ts_q;
  assign ts_eff = (tdiff == 8'd1 || tdiff == 8'd2) ? tail_q : ts_q;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = 9'd0;
    raddr = 9'd0;
    wdata = 8'd0;
    unique case (cmd_i.op)
      OP_RD_ID:   begin re = 1'b1; raddr = {1'b0, pos_q}; end
      OP_RD_HDR:  begin re = 1'b1; raddr = {1'b0, pos_q} + 9'd1; end
      OP_RD_BYTE: begin re = 1'b1; raddr = {1'b0, pos_q} + 9'd2 + {1'b0, j_q}; end
      OP_WR_SPLIT_ID: begin
        we = 1'b1; waddr = {1'b0, pos_q} + {1'b0, ts_q};
      end
      OP_WR_SPLIT_HDR: begin
        we = 1'b1; waddr = {1'b0, pos_q} + {1'b0, ts_q} + 9'd1; wdata = {diff[6:0], 1'b0};
      end
      OP_WR_ID:   begin we = 1'b1; waddr = {1'b0, pos_q}; wdata = idc_q + 8'd1; end
      OP_WR_HDR:  begin we = 1'b1; waddr = {1'b0, pos_q} + 9'd1; wdata = {ts_q[6:0], 1'b1}; end
      OP_WR_FREE: begin we = 1'b1; waddr = {1'b0, pos_q} + 9'd1; wdata = {hdr_q[7:1], 1'b0}; end
      OP_WR_FILL: begin
        we = 1'b1; waddr = {1'b0, pos_q} + 9'd2 + {1'b0, j_q}; wdata = req_q.fill_byte;
      end
      default: ;
    endcase
  end

  assign wr_ok = we && (waddr < 9'(HEAP_BYTES));

  ilha_ram #(.WIDTH(8), .DEPTH(HEAP_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rzero_q <= 1'b1;
      idc_q   <= 8'd0;
      cnt_q   <= 6'd0;
      tail_q  <= 8'(HEAP_BYTES);
      valid_q <= 1'b0;
    end else begin
      // Bytes never written read as zero.
      if (wr_ok) begin
        vld_q[waddr[AW-1:0]] <= 1'b1;
      end
      if (re) begin
        rzero_q <= (raddr >= 9'(HEAP_BYTES)) || !vld_q[raddr[AW-1:0]];
      end
      if (cmd_i.op == OP_WR_ID) begin
        idc_q <= idc_q + 8'd1;
      end
      if (cmd_i.op == OP_WR_SPLIT_HDR || cmd_i.op == OP_TAIL) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (cmd_i.op == OP_TAIL) begin
        tail_q <= tail_q - ts_eff;
      end
      valid_q <= cmd_i.emit;
    end
  end

  // The id counter has already stepped when the allocate word is built.
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = cmd_i.status;
    rsp_d.last   = 1'b1;
    unique case (cmd_i.sel)
      RSP_ALLOC:  rsp_d.result_id = idc_q;
      RSP_FREE:   rsp_d.result_id = req_q.target_id;
      RSP_HEADER: begin
        rsp_d.result_id        = id_q;
        rsp_d.result_size      = sz;
        rsp_d.result_allocated = hdr_q[0];
      end
      RSP_DATA: begin
        rsp_d.data_byte  = rdata;
        rsp_d.data_valid = 1'b1;
        rsp_d.last       = (j_q + 8'd1 == req_q.request_amount);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD:      req_q <= req_i;
      OP_WALK_INIT: begin
        pos_q <= 8'd0;
        i_q   <= 6'd0;
        j_q   <= 8'd0;
        ts_q  <= req_q.request_amount + 8'd2;
      end
      OP_RD_HDR:    id_q  <= rdata;
      OP_CAP_HDR:   hdr_q <= rdata;
      OP_STEP: begin
        pos_q <= pos_q + sz;
        i_q   <= i_q + 6'd1;
      end
      OP_FIT: begin
        if (diff == 8'd1 || diff == 8'd2) begin
          ts_q <= sz;
        end
      end
      OP_TAIL: begin
        ts_q  <= ts_eff;
        pos_q <= 8'(HEAP_BYTES) - tail_q;
      end
      OP_WR_FILL:   j_q <= j_q + 8'd1;
      default: ;
    endcase
    if (cmd_i.next_byte) begin
      j_q <= j_q + 8'd1;
    end
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    sts_o.action     = req_q.action;
    sts_o.walk_end   = (i_q >= cnt_q) || ({1'b0, pos_q} + 9'd2 > 9'(HEAP_BYTES));
    sts_o.id_match   = (id_q == req_q.target_id);
    sts_o.blk_alloc  = hdr_q[0];
    sts_o.fits       = !hdr_q[0] && (sz >= ts_q);
    sts_o.split      = (diff >= 8'd3);
    sts_o.too_big    = (req_q.request_amount >= TooBig);
    sts_o.table_full = (cnt_q >= MaxBlocks);
    sts_o.rd_bound   = (req_q.request_amount >= TooBig) || (req_q.request_amount > MaxOut);
    sts_o.tail_short = (tail_q < ts_q);
    sts_o.amt_over   = (sz >= 8'd2) && ({1'b0, req_q.request_amount} + 9'd2 > {1'b0, sz});
    sts_o.amt_zero   = (req_q.request_amount == 8'd0);
    sts_o.fill_done  = (j_q == req_q.request_amount);
    sts_o.read_last  = (j_q + 8'd1 == req_q.request_amount);
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= 8'(HEAP_BYTES)) else $error("tail space exceeds heap size");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxBlocks) else $error("block count exceeds table size");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && rsp_q.data_valid |-> rsp_q.status == STS_OK)
    else $error("payload byte with error status");

  a_tail_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_TAIL |=> tail_q < $past(tail_q))
    else $error("tail allocation did not consume space");

endmodule

`default_nettype wire

// File: hw/rtl/implicit_list_heap_allocator.sv
// Top level of the implicit list heap allocator.
// Depends on ilha_pkg, ilha_ctrl and ilha_dp.
//
// A request is taken when start is high and busy is low; busy then stays high until
// every result word of the request has been issued. Each result word appears on rsp_o
// for one cycle with valid_o high, and the receiver cannot stall it. A request passes
// through acceptance and decode, then a first-fit or id walk that reads the id and header
// byte of each block it visits, up to the end of the list; allocate then writes the
// headers of the new block and of any split remainder, write fills the payload one byte
// at a time, and read returns one result word per payload byte. The heap holds 64 bytes
// by default.
`default_nettype none

module implicit_list_heap_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ilha_pkg::req_t req_i,
  output logic                valid_o,
  output ilha_pkg::rsp_t      rsp_o
);
  import ilha_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ilha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ilha_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire
